// ===== sv/bpvw_pkg.sv =====
// shared types and constants of the bit packer with varint writer
// used by every module of the block, depends on nothing
package bpvw_pkg;

  localparam int CAP_W        = 16;
  localparam int BPOS_W       = 19;
  localparam int ACC_W        = 39;
  localparam int CNT_W        = 6;
  localparam int MAX_RAW_BITS = 32;
  localparam int PADDR_W      = 3;

  localparam logic [CAP_W-1:0] CAP_RESET    = 16'hFFFF;
  localparam logic             REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    FUNC_RAW    = 2'd0,
    FUNC_UVAR   = 2'd1,
    FUNC_ZVAR   = 2'd2,
    FUNC_FINISH = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic [5:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_offset;
    logic        is_summary;
    logic [15:0] byte_count;
    logic        overflow;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW_CHK,
    ST_RAW_EMIT,
    ST_VAR,
    ST_FIN,
    ST_SUM
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RAW_CHK,
    OP_RAW_EMIT,
    OP_VAR_STEP,
    OP_FIN_PART,
    OP_FIN_SUM
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic ovf;
    logic raw_fail;
    logic raw_more;
    logic var_fail;
    logic var_stop;
    logic part_pending;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/bpvw_regs.sv =====
// configuration register file behind the apb-style port
// depends on bpvw_pkg
module bpvw_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpvw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [bpvw_pkg::CAP_W-1:0]   capacity
);

  logic [bpvw_pkg::CAP_W-1:0] cap_r;
  logic [bpvw_pkg::CAP_W-1:0] cap_nxt;
  logic                       sel_cap;

  assign sel_cap = (paddr[bpvw_pkg::PADDR_W-1] == bpvw_pkg::REG_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && pready && sel_cap) begin
      cap_nxt = pwdata[bpvw_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bpvw_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign pready   = 1'b1;
  assign prdata   = sel_cap ? {{(32 - bpvw_pkg::CAP_W){1'b0}}, cap_r} : 32'd0;
  assign capacity = cap_r;

endmodule

// ===== sv/bpvw_datapath.sv =====
// packing datapath: message state, raw and varint byte assembly, result register
// depends on bpvw_pkg
module bpvw_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bpvw_pkg::dp_cmd_t          cmd,
  input  bpvw_pkg::in_item_t         in_data,
  input  logic [bpvw_pkg::CAP_W-1:0] capacity,
  input  logic                       out_ready,
  output logic                       out_valid,
  output bpvw_pkg::out_item_t        out_data,
  output bpvw_pkg::dp_status_t       status
);

  logic [7:0]                        part_r, part_nxt;
  logic [bpvw_pkg::BPOS_W-1:0]       bp_r, bp_nxt;
  logic                              ovf_r, ovf_nxt;
  logic [31:0]                       val_r, val_nxt;
  logic [bpvw_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [bpvw_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [bpvw_pkg::CNT_W-1:0]        t_r, t_nxt;
  logic [15:0]                       off_r, off_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bpvw_pkg::out_item_t               out_r, out_nxt;

  logic [bpvw_pkg::BPOS_W-1:0]       cap8;
  logic [bpvw_pkg::BPOS_W:0]         raw_sum;
  logic [bpvw_pkg::BPOS_W:0]         sum8;
  logic [bpvw_pkg::BPOS_W:0]         sum16;
  logic [bpvw_pkg::BPOS_W:0]         sum7;
  logic                              raw_fail;
  logic                              var_fail;
  logic                              next_fail;
  logic [31:0]                       rest;
  logic                              var_stop;
  logic [32:0]                       mask;
  logic [31:0]                       vmask;
  logic [bpvw_pkg::ACC_W-1:0]        raw_acc;
  logic [bpvw_pkg::CNT_W-1:0]        raw_t;
  logic [7:0]                        grp;
  logic [15:0]                       vacc;
  logic [31:0]                       zigzag;
  logic [bpvw_pkg::CNT_W-1:0]        cnt_clamp;
  logic                              out_free;
  logic                              part_pending;

  assign cap8      = {capacity, 3'b000};
  assign raw_sum   = {1'b0, bp_r} + (bpvw_pkg::BPOS_W + 1)'(cnt_r);
  assign sum8      = {1'b0, bp_r} + (bpvw_pkg::BPOS_W + 1)'(8);
  assign sum16     = {1'b0, bp_r} + (bpvw_pkg::BPOS_W + 1)'(16);
  assign sum7      = {1'b0, bp_r} + (bpvw_pkg::BPOS_W + 1)'(7);
  assign raw_fail  = raw_sum > {1'b0, cap8};
  assign var_fail  = sum8 > {1'b0, cap8};
  assign next_fail = sum16 > {1'b0, cap8};
  assign rest      = val_r >> 7;
  assign var_stop  = (rest == 32'd0) || next_fail;

  assign mask    = (33'd1 << cnt_r) - 33'd1;
  assign vmask   = val_r & mask[31:0];
  assign raw_acc = {31'd0, part_r} | (bpvw_pkg::ACC_W'(vmask) << bp_r[2:0]);
  assign raw_t   = {3'd0, bp_r[2:0]} + cnt_r;

  assign grp  = {(rest != 32'd0), val_r[6:0]};
  assign vacc = {8'd0, part_r} | (16'(grp) << bp_r[2:0]);

  assign zigzag    = {in_data.value[30:0], 1'b0} ^ {32{in_data.value[31]}};
  assign cnt_clamp = (in_data.bit_count > bpvw_pkg::CNT_W'(bpvw_pkg::MAX_RAW_BITS))
                   ? bpvw_pkg::CNT_W'(bpvw_pkg::MAX_RAW_BITS) : in_data.bit_count;

  assign out_free     = !out_valid_r || out_ready;
  assign part_pending = (bp_r[2:0] != 3'd0);

  always_comb begin
    part_nxt      = part_r;
    bp_nxt        = bp_r;
    ovf_nxt       = ovf_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    off_nxt       = off_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.op)
      bpvw_pkg::OP_LOAD: begin
        val_nxt = (in_data.func == bpvw_pkg::FUNC_ZVAR) ? zigzag : in_data.value;
        cnt_nxt = cnt_clamp;
      end
      bpvw_pkg::OP_RAW_CHK: begin
        if (!ovf_r) begin
          if (raw_fail) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = raw_acc;
            t_nxt   = raw_t;
            off_nxt = bp_r[bpvw_pkg::BPOS_W-1:3];
            bp_nxt  = raw_sum[bpvw_pkg::BPOS_W-1:0];
          end
        end
      end
      bpvw_pkg::OP_RAW_EMIT: begin
        if (t_r >= bpvw_pkg::CNT_W'(8)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{out_byte: acc_r[7:0], byte_offset: off_r, is_summary: 1'b0,
                        byte_count: 16'd0, overflow: 1'b0,
                        last: (t_r < bpvw_pkg::CNT_W'(16))};
            acc_nxt = acc_r >> 8;
            t_nxt   = t_r - bpvw_pkg::CNT_W'(8);
            off_nxt = off_r + 16'd1;
          end
        end else begin
          part_nxt = acc_r[7:0];
        end
      end
      bpvw_pkg::OP_VAR_STEP: begin
        if (!ovf_r) begin
          if (var_fail) begin
            ovf_nxt = 1'b1;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{out_byte: vacc[7:0], byte_offset: bp_r[bpvw_pkg::BPOS_W-1:3],
                        is_summary: 1'b0, byte_count: 16'd0, overflow: 1'b0,
                        last: var_stop};
            part_nxt = vacc[15:8];
            bp_nxt   = sum8[bpvw_pkg::BPOS_W-1:0];
            val_nxt  = rest;
            if ((rest != 32'd0) && next_fail) begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      bpvw_pkg::OP_FIN_PART: begin
        if (part_pending && out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_byte: part_r, byte_offset: bp_r[bpvw_pkg::BPOS_W-1:3],
                      is_summary: 1'b0, byte_count: 16'd0, overflow: 1'b0, last: 1'b0};
        end
      end
      bpvw_pkg::OP_FIN_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_byte: 8'd0, byte_offset: 16'd0, is_summary: 1'b1,
                      byte_count: sum7[bpvw_pkg::BPOS_W-1:3], overflow: ovf_r,
                      last: 1'b1};
          part_nxt = 8'd0;
          bp_nxt   = '0;
          ovf_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r      <= 8'd0;
      bp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      part_r      <= part_nxt;
      bp_r        <= bp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    t_r   <= t_nxt;
    off_r <= off_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign status = '{ovf: ovf_r, raw_fail: raw_fail,
                    raw_more: (t_r >= bpvw_pkg::CNT_W'(8)),
                    var_fail: var_fail, var_stop: var_stop,
                    part_pending: part_pending, out_free: out_free};

endmodule

// ===== sv/bpvw_ctrl.sv =====
// request sequencer: accepts a request and steps the datapath through it
// depends on bpvw_pkg
module bpvw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  output logic                 in_ready,
  input  bpvw_pkg::dp_status_t status,
  output bpvw_pkg::dp_cmd_t    cmd
);

  bpvw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpvw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.op    = bpvw_pkg::OP_NONE;
    unique case (state_r)
      bpvw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = bpvw_pkg::OP_LOAD;
          unique case (in_func)
            bpvw_pkg::FUNC_RAW:    state_nxt = bpvw_pkg::ST_RAW_CHK;
            bpvw_pkg::FUNC_UVAR:   state_nxt = bpvw_pkg::ST_VAR;
            bpvw_pkg::FUNC_ZVAR:   state_nxt = bpvw_pkg::ST_VAR;
            default:               state_nxt = bpvw_pkg::ST_FIN;
          endcase
        end
      end
      bpvw_pkg::ST_RAW_CHK: begin
        cmd.op = bpvw_pkg::OP_RAW_CHK;
        if (status.ovf || status.raw_fail) begin
          state_nxt = bpvw_pkg::ST_IDLE;
        end else begin
          state_nxt = bpvw_pkg::ST_RAW_EMIT;
        end
      end
      bpvw_pkg::ST_RAW_EMIT: begin
        cmd.op = bpvw_pkg::OP_RAW_EMIT;
        if (!status.raw_more) begin
          state_nxt = bpvw_pkg::ST_IDLE;
        end
      end
      bpvw_pkg::ST_VAR: begin
        cmd.op = bpvw_pkg::OP_VAR_STEP;
        if (status.ovf || status.var_fail) begin
          state_nxt = bpvw_pkg::ST_IDLE;
        end else if (status.out_free && status.var_stop) begin
          state_nxt = bpvw_pkg::ST_IDLE;
        end
      end
      bpvw_pkg::ST_FIN: begin
        cmd.op = bpvw_pkg::OP_FIN_PART;
        if (!status.part_pending || status.out_free) begin
          state_nxt = bpvw_pkg::ST_SUM;
        end
      end
      bpvw_pkg::ST_SUM: begin
        cmd.op = bpvw_pkg::OP_FIN_SUM;
        if (status.out_free) begin
          state_nxt = bpvw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpvw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bit_packer_varint_writer.sv =====
// top level: raw loads, checks, then sends its finished bytes; varint sends one byte
// per group; finish sends any partial byte and the summary; a stalled output waits
// results leave through a result register, one request is worked at a time
// rst_n (synchronous) empties the message, clears the overflow flag, capacity to 65535
// depends on bpvw_pkg, bpvw_regs, bpvw_ctrl, bpvw_datapath
module bit_packer_varint_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bpvw_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bpvw_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpvw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [bpvw_pkg::CAP_W-1:0] capacity;
  bpvw_pkg::dp_cmd_t          cmd;
  bpvw_pkg::dp_status_t       status;

  bpvw_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  bpvw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bpvw_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .capacity  (capacity),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_summary |-> out_data.last && out_data.out_byte == 8'd0)
    else $error("summary not marked last");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_summary |-> out_data.byte_count == 16'd0 && !out_data.overflow)
    else $error("data result carries summary fields");

endmodule
